// ===== design/gtc_pkg.sv =====
// ----------------------------------------------------------------------------
// gtc_pkg
// Shared types and constants of the graph tree checker.
// ----------------------------------------------------------------------------
package gtc_pkg;

    localparam int MAX_NODES = 256;
    localparam int MAX_EDGES = 512;

    localparam int NODE_W  = $clog2(MAX_NODES);      // node number
    localparam int CNT_W   = $clog2(MAX_NODES + 1);  // node count, 0..MAX_NODES
    localparam int EADDR_W = $clog2(MAX_EDGES);      // edge store address
    localparam int TOTAL_W = $clog2(MAX_EDGES + 1);  // edge count, 0..MAX_EDGES
    localparam int EDGE_W  = 2 * NODE_W;             // {node_a, node_b}

    // opcodes
    localparam logic OP_EDGE   = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } t_gtc_in;

    typedef struct packed {
        logic is_tree;
        logic fault;
    } t_gtc_out;

endpackage

// ===== design/gtc_ram.sv =====
// ----------------------------------------------------------------------------
// gtc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gtc_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered output
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== design/graph_tree_checker.sv =====
// ----------------------------------------------------------------------------
// graph_tree_checker
// Collects undirected edges and decides whether the graph is a tree.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item transfers when start is high and busy is low.
//   An edge item (opcode 0) is written to the edge store, or sets the fault
//   flag if the store is full; busy stays low, so edges stream in one per
//   cycle. A finish item (opcode 1) raises busy while the edge store is
//   scanned for out-of-range endpoints and, if no fault was found and the
//   edge count equals node_count - 1, walked depth first from node 0: per
//   reached node, a stack pop and then a pass over the edge store, read
//   through its single read port. The verdict appears on o_result for one
//   cycle with o_strobe, and busy drops in that cycle.
//   Results cannot be held off by the receiver.
//   Config channel: node_count transfers when i_cfg_valid and o_cfg_ready
//   are high; ready is always high, writes belong to idle periods.
//   Reset sets node_count to 1 and empties the edge store and visited map;
//   the memories need no clearing pass. After every verdict the edge store,
//   fault flag and visited map are emptied.
// ----------------------------------------------------------------------------
module graph_tree_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  gtc_pkg::t_gtc_in          i_item,
    output logic                      o_strobe,
    output gtc_pkg::t_gtc_out         o_result,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [gtc_pkg::CNT_W-1:0] i_cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RANGE = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_POP   = 3'd3;
    localparam logic [2:0] S_POPW  = 3'd4;

    localparam logic [gtc_pkg::CNT_W-1:0] NODES_MAX =
        gtc_pkg::CNT_W'(gtc_pkg::MAX_NODES);
    localparam logic [gtc_pkg::TOTAL_W-1:0] EDGES_MAX =
        gtc_pkg::TOTAL_W'(gtc_pkg::MAX_EDGES);

    logic [2:0]                     r_state, n_state;
    logic [gtc_pkg::CNT_W-1:0]      r_node_count;
    logic [gtc_pkg::TOTAL_W-1:0]    r_total, n_total;
    logic                           r_fault_seen, n_fault_seen;
    logic                           r_fault, n_fault;
    logic [gtc_pkg::TOTAL_W-1:0]    r_idx, n_idx;
    logic                           r_pend, n_pend;
    logic [gtc_pkg::MAX_NODES-1:0]  r_visited, n_visited;
    logic [gtc_pkg::CNT_W-1:0]      r_top, n_top;
    logic [gtc_pkg::CNT_W-1:0]      r_reached, n_reached;
    logic [gtc_pkg::NODE_W-1:0]     r_v, n_v;
    logic                           r_strobe, n_strobe;
    gtc_pkg::t_gtc_out              r_result, n_result;

    logic                           w_accept;
    logic [gtc_pkg::CNT_W-1:0]      w_nodes;
    logic                           e_we;
    logic [gtc_pkg::EDGE_W-1:0]     e_rdata;
    logic [gtc_pkg::NODE_W-1:0]     w_a, w_b, w_target;
    logic                           w_hit;
    logic                           s_we;
    logic [gtc_pkg::NODE_W-1:0]     s_rdata;
    logic [gtc_pkg::CNT_W-1:0]      w_top_m1;

    assign w_accept    = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_strobe;
    assign o_result    = r_result;

    // effective node count: zero counts as one, clamp at the maximum
    always_comb begin
        if (r_node_count == '0) begin
            w_nodes = gtc_pkg::CNT_W'(1);
        end else if (r_node_count > NODES_MAX) begin
            w_nodes = NODES_MAX;
        end else begin
            w_nodes = r_node_count;
        end
    end

    assign w_a      = e_rdata[gtc_pkg::EDGE_W-1:gtc_pkg::NODE_W];
    assign w_b      = e_rdata[gtc_pkg::NODE_W-1:0];
    assign w_top_m1 = r_top - gtc_pkg::CNT_W'(1);

    // neighbor of the current node on the edge just read
    always_comb begin
        w_hit    = 1'b0;
        w_target = w_b;
        if (w_a == r_v) begin
            w_hit    = 1'b1;
            w_target = w_b;
        end else if (w_b == r_v) begin
            w_hit    = 1'b1;
            w_target = w_a;
        end
    end

    assign e_we = w_accept && (i_item.opcode == gtc_pkg::OP_EDGE) && (r_total != EDGES_MAX);
    assign s_we = (r_state == S_WALK) && r_pend && w_hit && !r_visited[w_target];

    // edge store
    gtc_ram #(
        .DEPTH (gtc_pkg::MAX_EDGES),
        .WIDTH (gtc_pkg::EDGE_W)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (r_total[gtc_pkg::EADDR_W-1:0]),
        .i_wdata ({i_item.node_a, i_item.node_b}),
        .i_raddr (r_idx[gtc_pkg::EADDR_W-1:0]),
        .o_rdata (e_rdata)
    );

    // walk stack
    gtc_ram #(
        .DEPTH (gtc_pkg::MAX_NODES),
        .WIDTH (gtc_pkg::NODE_W)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (r_top[gtc_pkg::NODE_W-1:0]),
        .i_wdata (w_target),
        .i_raddr (w_top_m1[gtc_pkg::NODE_W-1:0]),
        .o_rdata (s_rdata)
    );

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_total      = r_total;
        n_fault_seen = r_fault_seen;
        n_fault      = r_fault;
        n_idx        = r_idx;
        n_pend       = 1'b0;
        n_visited    = r_visited;
        n_top        = r_top;
        n_reached    = r_reached;
        n_v          = r_v;
        n_strobe     = 1'b0;
        n_result     = r_result;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_item.opcode == gtc_pkg::OP_EDGE) begin
                        if (r_total == EDGES_MAX) begin
                            n_fault_seen = 1'b1;
                        end else begin
                            n_total = r_total + gtc_pkg::TOTAL_W'(1);
                        end
                    end else begin
                        n_fault = r_fault_seen;
                        n_idx   = '0;
                        n_state = S_RANGE;
                    end
                end
            end
            S_RANGE: begin
                // issue reads in order, check each returned edge
                if (r_idx != r_total) begin
                    n_idx  = r_idx + gtc_pkg::TOTAL_W'(1);
                    n_pend = 1'b1;
                end
                if (r_pend && (({1'b0, w_a} >= w_nodes) || ({1'b0, w_b} >= w_nodes))) begin
                    n_fault = 1'b1;
                end
                if ((r_idx == r_total) && !r_pend) begin
                    if (r_fault || (r_total != ({1'b0, w_nodes} - gtc_pkg::TOTAL_W'(1)))) begin
                        n_strobe         = 1'b1;
                        n_result.is_tree = 1'b0;
                        n_result.fault   = r_fault;
                        n_state          = S_IDLE;
                        n_total          = '0;
                        n_fault_seen     = 1'b0;
                        n_visited        = '0;
                    end else begin
                        // start the walk at node 0
                        n_visited[0] = 1'b1;
                        n_v          = '0;
                        n_reached    = gtc_pkg::CNT_W'(1);
                        n_top        = '0;
                        n_idx        = '0;
                        n_state      = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (r_idx != r_total) begin
                    n_idx  = r_idx + gtc_pkg::TOTAL_W'(1);
                    n_pend = 1'b1;
                end
                if (s_we) begin
                    n_visited[w_target] = 1'b1;
                    n_top               = r_top + gtc_pkg::CNT_W'(1);
                end
                if ((r_idx == r_total) && !r_pend) begin
                    if (r_top != '0) begin
                        n_state = S_POP;
                    end else begin
                        n_strobe         = 1'b1;
                        n_result.is_tree = (r_reached == w_nodes);
                        n_result.fault   = 1'b0;
                        n_state          = S_IDLE;
                        n_total          = '0;
                        n_fault_seen     = 1'b0;
                        n_visited        = '0;
                    end
                end
            end
            S_POP: begin
                // stack read issued at top - 1
                n_top   = w_top_m1;
                n_state = S_POPW;
            end
            S_POPW: begin
                n_v       = s_rdata;
                n_reached = r_reached + gtc_pkg::CNT_W'(1);
                n_idx     = '0;
                n_state   = S_WALK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node_count <= gtc_pkg::CNT_W'(1);
            r_total      <= '0;
            r_fault_seen <= 1'b0;
            r_pend       <= 1'b0;
            r_visited    <= '0;
            r_top        <= '0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_total      <= n_total;
            r_fault_seen <= n_fault_seen;
            r_pend       <= n_pend;
            r_visited    <= n_visited;
            r_top        <= n_top;
            r_strobe     <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                r_node_count <= i_cfg_data;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_fault   <= n_fault;
        r_idx     <= n_idx;
        r_reached <= n_reached;
        r_v       <= n_v;
        r_result  <= n_result;
    end

    // a verdict closes the finish command
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    // a verdict only follows a busy period
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without finish");

    // stack never holds more than the node space
    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= NODES_MAX)
        else $error("walk stack overflow");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for graph_tree_checker: edge streams and finish items
// with random gaps, each verdict predicted from a shadow copy of the edges.
// ----------------------------------------------------------------------------

// Shadow of the checker state; predicts one verdict per finish transfer
class tree_scoreboard;
    gtc_pkg::t_gtc_out          verdicts[$];
    logic [gtc_pkg::NODE_W-1:0] end_a[$];
    logic [gtc_pkg::NODE_W-1:0] end_b[$];
    bit                         overflow;
    int unsigned                node_reg = 1;
    int                         errors   = 0;

    function void set_count(int unsigned v);
        node_reg = v;
    endfunction

    // Fault check (overflow, endpoint range), then connected and acyclic test over the stored edges
    function gtc_pkg::t_gtc_out judge();
        gtc_pkg::t_gtc_out r;
        int unsigned       n;
        bit                bad;
        bit                seen[gtc_pkg::MAX_NODES];
        int                frontier[$];
        int                v;
        int unsigned       reached;
        n = (node_reg == 0) ? 1 :
            (node_reg > gtc_pkg::MAX_NODES ? gtc_pkg::MAX_NODES : node_reg);
        bad = overflow;
        foreach (end_a[i])
            if (end_a[i] >= n || end_b[i] >= n) bad = 1;
        r.fault   = bad;
        r.is_tree = 1'b0;
        if (!bad) begin
            foreach (seen[i]) seen[i] = 0;
            seen[0] = 1;
            frontier = {frontier, 0};
            reached = 0;
            while (frontier.size() > 0) begin
                v = frontier.pop_back();
                reached++;
                foreach (end_a[i]) begin
                    if (end_a[i] == v && !seen[end_b[i]]) begin
                        seen[end_b[i]] = 1;
                        frontier = {frontier, int'(end_b[i])};
                    end
                    if (end_b[i] == v && !seen[end_a[i]]) begin
                        seen[end_a[i]] = 1;
                        frontier = {frontier, int'(end_a[i])};
                    end
                end
            end
            r.is_tree = (reached == n) && (end_a.size() == n - 1);
        end
        return r;
    endfunction

    function void note_item(gtc_pkg::t_gtc_in it);
        if (it.opcode == gtc_pkg::OP_EDGE) begin
            if (end_a.size() >= gtc_pkg::MAX_EDGES) begin
                overflow = 1;
            end else begin
                end_a = {end_a, it.node_a};
                end_b = {end_b, it.node_b};
            end
        end else begin
            verdicts = {verdicts, judge()};
            end_a.delete();
            end_b.delete();
            overflow = 0;
        end
    endfunction

    function void check(gtc_pkg::t_gtc_out got);
        gtc_pkg::t_gtc_out want;
        if (verdicts.size() == 0) begin
            $error("verdict with none expected: is_tree %0d fault %0d",
                   got.is_tree, got.fault);
            errors++;
            return;
        end
        want = verdicts.pop_front();
        if (got.is_tree !== want.is_tree) begin
            $error("is_tree: expected %0d, actual %0d", want.is_tree, got.is_tree);
            errors++;
        end
        if (got.fault !== want.fault) begin
            $error("fault: expected %0d, actual %0d", want.fault, got.fault);
            errors++;
        end
    endfunction
endclass

module testbench;
    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    gtc_pkg::t_gtc_in          i_item = '0;
    logic                      o_strobe;
    gtc_pkg::t_gtc_out         o_result;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [gtc_pkg::CNT_W-1:0] i_cfg_data = '0;

    tree_scoreboard sb = new();
    int             sent = 0;
    bit             no_gaps = 0;
    int unsigned    eff_n = 1;

    graph_tree_checker i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_strobe(o_strobe), .o_result(o_result),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Verdict monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) sb.check(o_result);
    end

    // One command transfer, with a random lead-in gap unless no_gaps is set
    task automatic send(logic op, int a, int b);
        gtc_pkg::t_gtc_in it;
        int unsigned      gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        it.opcode = op;
        it.node_a = a[gtc_pkg::NODE_W-1:0];
        it.node_b = b[gtc_pkg::NODE_W-1:0];
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        sb.note_item(it);
        sent++;
    endtask

    task automatic edge_item(int a, int b);
        if ($urandom_range(0, 1)) send(gtc_pkg::OP_EDGE, a, b);
        else send(gtc_pkg::OP_EDGE, b, a);
    endtask

    task automatic finish_item();
        send(gtc_pkg::OP_FINISH, $urandom_range(0, 255), $urandom_range(0, 255));
    endtask

    // Count write only once every verdict is in and the walk has settled
    task automatic write_count(int unsigned v);
        start <= 1'b0;
        while (sb.verdicts.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v[gtc_pkg::CNT_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_count(v);
        eff_n = (v == 0) ? 1 : (v > gtc_pkg::MAX_NODES ? gtc_pkg::MAX_NODES : v);
    endtask

    // Random graph on the current node count, shaped by kind
    task automatic send_graph(int kind);
        int perm[gtc_pkg::MAX_NODES];
        int ga[$];
        int gb[$];
        int j, t, k;
        for (int i = 0; i < eff_n; i++) perm[i] = i;
        for (int i = eff_n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = perm[i]; perm[i] = perm[j]; perm[j] = t;
        end
        for (int i = 1; i < eff_n; i++) begin
            ga = {ga, perm[i]};
            gb = {gb, perm[$urandom_range(0, i - 1)]};
        end
        case (kind)
            1: begin  // one extra edge closes a cycle or loops on itself
                ga = {ga, int'($urandom_range(0, eff_n - 1))};
                gb = {gb, int'($urandom_range(0, eff_n - 1))};
            end
            2: if (ga.size() > 0) begin  // split into two parts
                k = $urandom_range(0, ga.size() - 1);
                ga.delete(k); gb.delete(k);
            end
            3: if (ga.size() > 1) begin  // right count, but a duplicate edge
                k = $urandom_range(1, ga.size() - 1);
                ga[k] = ga[0]; gb[k] = gb[0];
            end
            4: begin  // endpoint beyond the node count
                if (eff_n < gtc_pkg::MAX_NODES) begin
                    ga = {ga, int'($urandom_range(eff_n, 255))};
                    gb = {gb, int'($urandom_range(0, 255))};
                end
            end
            5: begin  // noise over the full endpoint range
                ga.delete(); gb.delete();
                repeat ($urandom_range(0, 8)) begin
                    ga = {ga, int'($urandom_range(0, 255))};
                    gb = {gb, int'($urandom_range(0, 255))};
                end
            end
            default: ;
        endcase
        for (int i = ga.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = ga[i]; ga[i] = ga[j]; ga[j] = t;
            t = gb[i]; gb[i] = gb[j]; gb[j] = t;
        end
        foreach (ga[i]) edge_item(ga[i], gb[i]);
        finish_item();
    endtask

    initial begin
        int unsigned pick;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: single node, self loop, tiny trees, duplicates, range
        finish_item();
        send(gtc_pkg::OP_EDGE, 0, 0); finish_item();
        write_count(2);
        send(gtc_pkg::OP_EDGE, 0, 1); finish_item();
        send(gtc_pkg::OP_EDGE, 1, 0); send(gtc_pkg::OP_EDGE, 1, 0); finish_item();
        send(gtc_pkg::OP_EDGE, 2, 0); finish_item();
        send(gtc_pkg::OP_EDGE, 255, 255); finish_item();
        write_count(0);
        finish_item();
        write_count(3);
        send(gtc_pkg::OP_EDGE, 0, 1); send(gtc_pkg::OP_EDGE, 1, 2);
        send(gtc_pkg::OP_EDGE, 2, 0);
        finish_item();
        // Full-size register values, node count clamped to the maximum
        write_count(511);
        send_graph(0);
        write_count(256);
        send_graph(5);
        // Store overflow: one edge past capacity
        write_count(1);
        no_gaps = 1;
        repeat (gtc_pkg::MAX_EDGES + 1) send(gtc_pkg::OP_EDGE, 0, 0);
        no_gaps = 0;
        finish_item();

        // Random phases of node counts and graph shapes
        while (sent < 950) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)      write_count($urandom_range(257, 511));
            else if (pick == 1) write_count(0);
            else if (pick < 4)  write_count($urandom_range(17, 64));
            else                write_count($urandom_range(1, 16));
            no_gaps = ($urandom_range(0, 3) == 0);
            if (eff_n > 64) begin
                send_graph(5);
            end else begin
                repeat ($urandom_range(2, 6)) begin
                    pick = $urandom_range(0, 9);
                    if (sent < 950)
                        send_graph(pick < 4 ? 0 : pick - 3 > 5 ? 5 : pick - 3);
                end
            end
        end

        start <= 1'b0;
        while (sb.verdicts.size() > 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

    // Watchdog
    initial begin
        #20000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== filelist.f =====
design/gtc_pkg.sv
design/gtc_ram.sv
design/graph_tree_checker.sv
dv/testbench.sv
